// ===== rtl/tsfm_pkg.sv =====
package tsfm_pkg;

  localparam int FRAC_BITS      = 24;
  localparam int GRADE_BITS_DEF = 16;
  localparam int VAL_W          = 64;
  localparam int WEIGHT_W       = 16;
  localparam int MODE_W         = 2;
  localparam int IDX_W          = 3;

  localparam logic [MODE_W-1:0] MODE_LOWER  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_HIGHER = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BAND   = 2'd2;

  localparam logic [IDX_W-1:0] REG_CURVE_MODE   = 3'd0;
  localparam logic [IDX_W-1:0] REG_LOW_START    = 3'd1;
  localparam logic [IDX_W-1:0] REG_LOW_END      = 3'd2;
  localparam logic [IDX_W-1:0] REG_HIGH_START   = 3'd3;
  localparam logic [IDX_W-1:0] REG_HIGH_END     = 3'd4;
  localparam logic [IDX_W-1:0] REG_BLEND_WEIGHT = 3'd5;

  // Which grade rises on the chosen segment, or which one is pinned at one.
  localparam logic [2:0] SEG_WEAK_ONE   = 3'd0;
  localparam logic [2:0] SEG_LO_A       = 3'd1; // medium rises, weak falls
  localparam logic [2:0] SEG_LO_B       = 3'd2; // strong rises, medium falls
  localparam logic [2:0] SEG_STRONG_ONE = 3'd3;
  localparam logic [2:0] SEG_HI_A       = 3'd4; // medium rises, strong falls
  localparam logic [2:0] SEG_HI_B       = 3'd5; // weak rises, medium falls

endpackage

// ===== rtl/three_set_fuzzy_membership.sv =====
// Three-set piecewise-linear fuzzifier.
// Input channel: sample_valid/sample_ready with sample_value (signed Q39.24).
// Output channel: grade_valid/grade_ready with weak_grade, medium_grade and
// strong_grade, each unsigned with 2^GRADE_BITS meaning one.
// Configuration channel: cfg_valid/cfg_ready with cfg_index and cfg_data; it
// is always ready, and should only be written while no request is in flight.
// One request is taken every cycle while the output is not stalled: the
// quotient is formed by a restoring divider with one bit per pipeline stage.
// The knee offsets are recomputed from the registers through two register
// stages after each configuration write.
// When the receiver stalls, the whole pipeline holds and sample_ready falls;
// nothing is lost or repeated. Reset empties the pipeline and loads the
// register defaults (band mode, all breakpoints zero, weight one half).
module three_set_fuzzy_membership #(
  parameter int GRADE_BITS = tsfm_pkg::GRADE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tsfm_pkg::IDX_W-1:0]      cfg_index,
  input  logic [tsfm_pkg::VAL_W-1:0]      cfg_data,
  input  logic                            sample_valid,
  output logic                            sample_ready,
  input  logic signed [tsfm_pkg::VAL_W-1:0] sample_value,
  output logic                            grade_valid,
  input  logic                            grade_ready,
  output logic [GRADE_BITS:0]             weak_grade,
  output logic [GRADE_BITS:0]             medium_grade,
  output logic [GRADE_BITS:0]             strong_grade
);
  import tsfm_pkg::*;

  localparam logic [VAL_W-1:0] BIAS = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic [GRADE_BITS:0] ONE = {1'b1, {GRADE_BITS{1'b0}}};
  // Breakpoints are Q(63-FRAC_BITS).FRAC_BITS; the arithmetic works on raw bits.

  logic [MODE_W-1:0]   curve_mode;
  logic [VAL_W-1:0]    low_start, low_end, high_start, high_end;
  logic [WEIGHT_W-1:0] blend_weight;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      curve_mode   <= MODE_BAND;
      low_start    <= '0;
      low_end      <= '0;
      high_start   <= '0;
      high_end     <= '0;
      blend_weight <= 16'd32768;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_CURVE_MODE:   curve_mode   <= cfg_data[MODE_W-1:0];
        REG_LOW_START:    low_start    <= cfg_data;
        REG_LOW_END:      low_end      <= cfg_data;
        REG_HIGH_START:   high_start   <= cfg_data;
        REG_HIGH_END:     high_end     <= cfg_data;
        REG_BLEND_WEIGHT: blend_weight <= cfg_data[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Derived thresholds, biased so that unsigned order is signed order.
  logic [VAL_W-1:0] bu, bt, bT, bU, wl, wh;
  assign bu = low_start ^ BIAS;
  assign bt = low_end ^ BIAS;
  assign bT = high_start ^ BIAS;
  assign bU = high_end ^ BIAS;
  assign wl = (bt > bu) ? bt - bu : '0;
  assign wh = (bU > bT) ? bU - bT : '0;

  // Knee products registered: 32x16 partial products, then summed.
  logic [47:0] pl_hi, pl_lo, ph_hi, ph_lo;
  logic [VAL_W-1:0] m_knee, mu_knee;
  logic [VAL_W-1:0] koff_l, koff_h;
  always_ff @(posedge clk) begin
    pl_hi <= {16'd0, wl[63:32]} * {32'd0, blend_weight};
    pl_lo <= {16'd0, wl[31:0]}  * {32'd0, blend_weight};
    ph_hi <= {16'd0, wh[63:32]} * {32'd0, blend_weight};
    ph_lo <= {16'd0, wh[31:0]}  * {32'd0, blend_weight};
  end
  assign koff_l = {pl_hi[47:0], 16'd0} + {32'd0, pl_lo[47:16]};
  assign koff_h = {ph_hi[47:0], 16'd0} + {32'd0, ph_lo[47:16]};
  always_ff @(posedge clk) begin
    m_knee  <= bu + koff_l;
    mu_knee <= (wh != '0) ? bU - koff_h : bU;
  end

  logic advance;
  logic s1_v, s2_v;
  logic div_v;
  logic [GRADE_BITS:0] div_q;
  logic [2:0] div_seg;

  assign advance      = !grade_valid || grade_ready;
  assign sample_ready = advance;

  // Stage 1: compare against the six thresholds.
  logic [VAL_W-1:0] s1_x;
  logic [5:0] s1_lt;
  logic [MODE_W-1:0] s1_mode;
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (advance) begin
      s1_v <= sample_valid;
    end
    if (advance) begin
      s1_x    <= sample_value ^ BIAS;
      s1_lt   <= {(sample_value ^ BIAS) < bU, (sample_value ^ BIAS) < mu_knee,
                  (sample_value ^ BIAS) < bT, (sample_value ^ BIAS) < bt,
                  (sample_value ^ BIAS) < m_knee, (sample_value ^ BIAS) < bu};
      s1_mode <= curve_mode;
    end
  end

  // Stage 2: choose the segment and form the divider operands.
  logic [2:0] seg_sel;
  logic [VAL_W-1:0] seg_lo, seg_hi;
  logic lower, higher;
  assign lower  = (s1_mode == MODE_LOWER);
  assign higher = (s1_mode == MODE_HIGHER);
  always_comb begin
    seg_lo = '0;
    seg_hi = '0;
    priority if (!lower && s1_lt[0]) begin
      seg_sel = SEG_WEAK_ONE;
    end else if (!lower && s1_lt[1]) begin
      seg_sel = SEG_LO_A; seg_lo = bu; seg_hi = m_knee;
    end else if (!lower && s1_lt[2]) begin
      seg_sel = SEG_LO_B; seg_lo = m_knee; seg_hi = bt;
    end else if (higher || s1_lt[3]) begin
      seg_sel = SEG_STRONG_ONE;
    end else if (s1_lt[4]) begin
      seg_sel = SEG_HI_A; seg_lo = bT; seg_hi = mu_knee;
    end else if (s1_lt[5]) begin
      seg_sel = SEG_HI_B; seg_lo = mu_knee; seg_hi = bU;
    end else begin
      seg_sel = SEG_WEAK_ONE;
    end
  end

  logic [VAL_W-1:0] s2_d, s2_len;
  logic [2:0] s2_seg;
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (advance) begin
      s2_v <= s1_v;
    end
    if (advance) begin
      s2_d   <= s1_x - seg_lo;
      s2_len <= seg_hi - seg_lo;
      s2_seg <= seg_sel;
    end
  end

  tsfm_divider #(.GRADE_BITS(GRADE_BITS)) u_div (
    .clk(clk), .rst(rst), .advance(advance),
    .in_valid(s2_v), .in_d(s2_d), .in_len(s2_len), .in_seg(s2_seg),
    .out_valid(div_v), .out_q(div_q), .out_seg(div_seg)
  );

  // Output stage: map the quotient to the grades and clear on a full grade.
  logic [GRADE_BITS:0] gw, gm, gs, rise, fall;
  assign rise = div_q;
  assign fall = ONE - div_q;
  always_comb begin
    gw = '0; gm = '0; gs = '0;
    unique case (div_seg)
      SEG_WEAK_ONE:   gw = ONE;
      SEG_LO_A:       begin gm = rise; gw = fall; end
      SEG_LO_B:       begin gs = rise; gm = fall; end
      SEG_STRONG_ONE: gs = ONE;
      SEG_HI_A:       begin gm = rise; gs = fall; end
      SEG_HI_B:       begin gw = rise; gm = fall; end
      default:        gw = ONE;
    endcase
    if (gw == ONE) begin
      gm = '0; gs = '0;
    end else if (gm == ONE) begin
      gw = '0; gs = '0;
    end else if (gs == ONE) begin
      gw = '0; gm = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grade_valid <= 1'b0;
    end else if (advance) begin
      grade_valid <= div_v;
    end
    if (advance) begin
      weak_grade   <= gw;
      medium_grade <= gm;
      strong_grade <= gs;
    end
  end

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    grade_valid && !grade_ready |=> grade_valid && $stable(weak_grade)
      && $stable(medium_grade) && $stable(strong_grade))
    else $error("result changed during stall");

  a_grades_sum: assert property (@(posedge clk) disable iff (rst)
    grade_valid |-> ({1'b0, weak_grade} + {1'b0, medium_grade} + {1'b0, strong_grade})
      == {1'b0, ONE})
    else $error("grades do not sum to one");

  a_ready_follows: assert property (@(posedge clk) disable iff (rst)
    sample_ready == (!grade_valid || grade_ready))
    else $error("ready does not follow output stall");

endmodule

// ===== rtl/tsfm_divider.sv =====
module tsfm_divider #(
  parameter int GRADE_BITS = tsfm_pkg::GRADE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           advance,
  input  logic                           in_valid,
  input  logic [tsfm_pkg::VAL_W-1:0]     in_d,
  input  logic [tsfm_pkg::VAL_W-1:0]     in_len,
  input  logic [2:0]                     in_seg,
  output logic                           out_valid,
  output logic [GRADE_BITS:0]            out_q,
  output logic [2:0]                     out_seg
);
  import tsfm_pkg::*;

  // One quotient bit per stage; a bit shifted out at the top of the
  // remainder forces that quotient bit.
  logic                  v   [GRADE_BITS+1];
  logic [VAL_W-1:0]      r   [GRADE_BITS+1];
  logic [VAL_W-1:0]      len [GRADE_BITS+1];
  logic [GRADE_BITS-1:0] q   [GRADE_BITS+1];
  logic                  one [GRADE_BITS+1];
  logic [2:0]            sg  [GRADE_BITS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (advance) begin
      v[0] <= in_valid;
    end
    if (advance) begin
      r[0]   <= in_d;
      len[0] <= in_len;
      q[0]   <= '0;
      one[0] <= (in_d >= in_len);
      sg[0]  <= in_seg;
    end
  end

  for (genvar i = 0; i < GRADE_BITS; i++) begin : g_stage
    logic             carry;
    logic [VAL_W-1:0] sh;
    logic             bit_q;
    assign carry = r[i][VAL_W-1];
    assign sh    = {r[i][VAL_W-2:0], 1'b0};
    assign bit_q = carry || (sh >= len[i]);
    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (advance) begin
        v[i+1] <= v[i];
      end
      if (advance) begin
        r[i+1]   <= bit_q ? sh - len[i] : sh;
        len[i+1] <= len[i];
        q[i+1]   <= {q[i][GRADE_BITS-2:0], bit_q};
        one[i+1] <= one[i];
        sg[i+1]  <= sg[i];
      end
    end
  end

  assign out_valid = v[GRADE_BITS];
  assign out_seg   = sg[GRADE_BITS];
  assign out_q     = one[GRADE_BITS] ? {1'b1, {GRADE_BITS{1'b0}}}
                                     : {1'b0, q[GRADE_BITS]};

endmodule
